>>> rtl/epr_pkg.sv
// Shared types, codes and constants for the e-paper refresh profile policy.
`timescale 1ns / 1ps
`default_nettype none

package epr_pkg;

    localparam int ACTION_W  = 2;
    localparam int REASON_W  = 4;
    localparam int TURNS_W   = 16;
    localparam int TIME_W    = 32;
    localparam int PROF_W    = 3;
    localparam int CAUSE_W   = 3;
    localparam int COUNT_W   = 16;
    localparam int TOTAL_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // actions
    localparam logic [ACTION_W-1:0] ACT_DECIDE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SUBMIT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QDONE  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd3;

    // profiles
    localparam logic [PROF_W-1:0] PROF_QUALITY = 3'd0;
    localparam logic [PROF_W-1:0] PROF_TEXT    = 3'd1;
    localparam logic [PROF_W-1:0] PROF_FAST    = 3'd2;
    localparam logic [PROF_W-1:0] PROF_FASTEST = 3'd3;

    // request reasons
    localparam logic [REASON_W-1:0] RSN_BOOT           = 4'd0;
    localparam logic [REASON_W-1:0] RSN_OPEN_BOOK      = 4'd1;
    localparam logic [REASON_W-1:0] RSN_RAPID_TURN     = 4'd3;
    localparam logic [REASON_W-1:0] RSN_MENU_OPEN      = 4'd5;
    localparam logic [REASON_W-1:0] RSN_MENU_CLOSE     = 4'd6;
    localparam logic [REASON_W-1:0] RSN_TOUCH          = 4'd8;
    localparam logic [REASON_W-1:0] RSN_FONT_REFLOW    = 4'd9;
    localparam logic [REASON_W-1:0] RSN_TOC            = 4'd10;
    localparam logic [REASON_W-1:0] RSN_WAKE           = 4'd11;
    localparam logic [REASON_W-1:0] RSN_GHOST_CLEANUP  = 4'd12;
    localparam logic [REASON_W-1:0] RSN_MANUAL_CLEANUP = 4'd13;
    localparam logic [REASON_W-1:0] RSN_ERROR          = 4'd14;

    // cleanup causes
    localparam logic [CAUSE_W-1:0] CAUSE_NONE    = 3'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_FASTEST = 3'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_FAST    = 3'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_READING = 3'd3;
    localparam logic [CAUSE_W-1:0] CAUSE_TIMEOUT = 3'd4;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RAPID_TURNS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FASTEST_LIM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_LIM    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_READING_LIM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 3'd4;

    localparam logic [COUNT_W-1:0] RST_RAPID_TURNS = 16'd3;
    localparam logic [COUNT_W-1:0] RST_FASTEST_LIM = 16'd3;
    localparam logic [COUNT_W-1:0] RST_FAST_LIM    = 16'd8;
    localparam logic [COUNT_W-1:0] RST_READING_LIM = 16'd12;
    localparam logic [TIME_W-1:0]  RST_TIMEOUT     = 32'd600000;

    typedef struct packed {
        logic [TURNS_W-1:0] rapid_turns_for_fastest;
        logic [COUNT_W-1:0] fastest_cap;
        logic [COUNT_W-1:0] fast_cap;
        logic [COUNT_W-1:0] reading_cap;
        logic [TIME_W-1:0]  quality_timeout_ms;
    } cfg_t;

    // classified item passed from front to back
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [REASON_W-1:0] reason;
        logic                partial;
        logic [TIME_W-1:0]   now_ms;
        logic [PROF_W-1:0]   req_prof;
        logic                check;
        logic [PROF_W-1:0]   sprof;
        logic                spart;
    } q_item_t;

endpackage

`default_nettype wire

>>> rtl/epr_in_if.sv
// Request channel interface: valid/ready plus request fields.
`timescale 1ns / 1ps
`default_nettype none

interface epr_in_if;
    import epr_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [REASON_W-1:0] req_reason;
    logic                full_screen;
    logic [TURNS_W-1:0]  rapid_turns;
    logic [TIME_W-1:0]   now_ms;
    logic [PROF_W-1:0]   submitted_profile;
    logic                submitted_partial;

    modport source (
        output valid, action, req_reason, full_screen, rapid_turns, now_ms,
               submitted_profile, submitted_partial,
        input  ready
    );

    modport sink (
        input  valid, action, req_reason, full_screen, rapid_turns, now_ms,
               submitted_profile, submitted_partial,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/epr_out_if.sv
// Result channel interface: valid/ready plus result fields.
`timescale 1ns / 1ps
`default_nettype none

interface epr_out_if;
    import epr_pkg::*;

    logic                valid;
    logic                ready;
    logic [PROF_W-1:0]   requested_profile;
    logic [PROF_W-1:0]   effective_profile;
    logic [REASON_W-1:0] result_reason;
    logic                result_partial;
    logic [TIME_W-1:0]   submitted_time;
    logic                cleanup_forced;
    logic [CAUSE_W-1:0]  cleanup_cause;
    logic [TOTAL_W-1:0]  cleanup_total;

    modport source (
        output valid, requested_profile, effective_profile, result_reason,
               result_partial, submitted_time, cleanup_forced, cleanup_cause,
               cleanup_total,
        input  ready
    );

    modport sink (
        input  valid, requested_profile, effective_profile, result_reason,
               result_partial, submitted_time, cleanup_forced, cleanup_cause,
               cleanup_total,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/epr_front.sv
// Front end: accepts request items and classifies the reason into a profile.
`timescale 1ns / 1ps
`default_nettype none

module epr_front (
    input  wire logic [epr_pkg::TURNS_W-1:0] rapid_turns_for_fastest,
    epr_in_if.sink                           request,
    input  wire logic                        q_full,
    output logic                             push,
    output epr_pkg::q_item_t                 push_item
);
    import epr_pkg::*;

    logic [PROF_W-1:0] req_prof;
    logic              reading;
    logic              eligible;

    always_comb
    begin
        unique case (request.req_reason)
            RSN_BOOT, RSN_WAKE, RSN_MANUAL_CLEANUP, RSN_GHOST_CLEANUP, RSN_ERROR:
            begin
                req_prof = PROF_QUALITY;
            end
            RSN_OPEN_BOOK, RSN_FONT_REFLOW, RSN_TOC:
            begin
                req_prof = PROF_TEXT;
            end
            RSN_RAPID_TURN:
            begin
                req_prof = (request.rapid_turns >= rapid_turns_for_fastest)
                           ? PROF_FASTEST : PROF_FAST;
            end
            default:
            begin
                req_prof = PROF_FAST;
            end
        endcase
    end

    assign reading  = (req_prof == PROF_FAST) || (req_prof == PROF_FASTEST);
    assign eligible = (request.req_reason != RSN_TOUCH)
                   && (request.req_reason != RSN_MENU_OPEN)
                   && (request.req_reason != RSN_MENU_CLOSE);

    assign request.ready = !q_full;
    assign push          = request.valid && !q_full;

    always_comb
    begin
        push_item.action   = request.action;
        push_item.reason   = request.req_reason;
        push_item.partial  = !request.full_screen;
        push_item.now_ms   = request.now_ms;
        push_item.req_prof = req_prof;
        push_item.check    = reading && eligible;
        push_item.sprof    = request.submitted_profile;
        push_item.spart    = request.submitted_partial;
    end
endmodule

`default_nettype wire

>>> rtl/epr_queue.sv
// Two-entry queue decoupling the classifier from the policy engine.
`timescale 1ns / 1ps
`default_nettype none

module epr_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire epr_pkg::q_item_t push_item,
    output logic                  full,
    input  wire logic             pop,
    output logic                  valid,
    output epr_pkg::q_item_t      head_item
);
    import epr_pkg::*;

    q_item_t    mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign valid     = (count_reg != 2'd0);
    assign head_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end
endmodule

`default_nettype wire

>>> rtl/epr_back.sv
// Back end: ghosting counters, cleanup decision and the result register.
`timescale 1ns / 1ps
`default_nettype none

module epr_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire epr_pkg::cfg_t    cfg,
    input  wire logic             q_valid,
    input  wire epr_pkg::q_item_t q_item,
    output logic                  pop,
    epr_out_if.source             result
);
    import epr_pkg::*;

    logic [COUNT_W-1:0]  fast_count_reg,     fast_count_next;
    logic [COUNT_W-1:0]  fastest_count_reg,  fastest_count_next;
    logic [COUNT_W-1:0]  partial_count_reg,  partial_count_next;
    logic [COUNT_W-1:0]  reading_count_reg,  reading_count_next;
    logic [TIME_W-1:0]   last_quality_reg,   last_quality_next;
    logic [TOTAL_W-1:0]  total_reg,          total_next;

    logic                out_valid_reg;
    logic [PROF_W-1:0]   req_prof_reg,       req_prof_next;
    logic [PROF_W-1:0]   eff_prof_reg,       eff_prof_next;
    logic [REASON_W-1:0] reason_reg,         reason_next;
    logic                partial_reg,        partial_next;
    logic [TIME_W-1:0]   time_reg,           time_next;
    logic                forced_reg,         forced_next;
    logic [CAUSE_W-1:0]  cause_reg,          cause_next;
    logic [TOTAL_W-1:0]  total_out_reg;

    logic                fastest_hit;
    logic                fast_hit;
    logic                reading_hit;
    logic                timeout_hit;
    logic [TIME_W-1:0]   elapsed;
    logic [CAUSE_W-1:0]  cause;
    logic                quality;

    assign pop = q_valid && (!out_valid_reg || result.ready);

    assign fastest_hit = ({1'b0, fastest_count_reg} + 17'd1) >= {1'b0, cfg.fastest_cap};
    assign fast_hit    = ({1'b0, fast_count_reg} + 17'd1) >= {1'b0, cfg.fast_cap};
    assign reading_hit = ({1'b0, reading_count_reg} + 17'd1) >= {1'b0, cfg.reading_cap};
    assign elapsed     = q_item.now_ms - last_quality_reg;
    assign timeout_hit = (last_quality_reg != '0) && (elapsed >= cfg.quality_timeout_ms);

    always_comb
    begin
        cause = CAUSE_NONE;
        if (q_item.check)
        begin
            priority if (q_item.req_prof == PROF_FASTEST && fastest_hit)
            begin
                cause = CAUSE_FASTEST;
            end
            else if (q_item.req_prof == PROF_FAST && fast_hit)
            begin
                cause = CAUSE_FAST;
            end
            else if (reading_hit)
            begin
                cause = CAUSE_READING;
            end
            else if (timeout_hit)
            begin
                cause = CAUSE_TIMEOUT;
            end
            else
            begin
                cause = CAUSE_NONE;
            end
        end
    end

    always_comb
    begin
        fast_count_next    = fast_count_reg;
        fastest_count_next = fastest_count_reg;
        partial_count_next = partial_count_reg;
        reading_count_next = reading_count_reg;
        last_quality_next  = last_quality_reg;
        total_next         = total_reg;
        quality            = 1'b0;

        req_prof_next = PROF_QUALITY;
        eff_prof_next = PROF_QUALITY;
        reason_next   = '0;
        partial_next  = 1'b0;
        time_next     = '0;
        forced_next   = 1'b0;
        cause_next    = CAUSE_NONE;

        unique case (q_item.action)
            ACT_DECIDE:
            begin
                req_prof_next = q_item.req_prof;
                eff_prof_next = (cause != CAUSE_NONE) ? PROF_QUALITY : q_item.req_prof;
                reason_next   = (cause != CAUSE_NONE) ? RSN_GHOST_CLEANUP : q_item.reason;
                partial_next  = q_item.partial;
                time_next     = q_item.now_ms;
                forced_next   = (cause != CAUSE_NONE);
                cause_next    = cause;
            end
            ACT_SUBMIT:
            begin
                if (q_item.sprof == PROF_QUALITY)
                begin
                    quality = 1'b1;
                end
                else
                begin
                    if (q_item.sprof == PROF_FAST && fast_count_reg != '1)
                    begin
                        fast_count_next = fast_count_reg + 16'd1;
                    end
                    if (q_item.sprof == PROF_FASTEST && fastest_count_reg != '1)
                    begin
                        fastest_count_next = fastest_count_reg + 16'd1;
                    end
                    if ((q_item.sprof == PROF_FAST || q_item.sprof == PROF_FASTEST
                         || q_item.sprof == PROF_TEXT) && reading_count_reg != '1)
                    begin
                        reading_count_next = reading_count_reg + 16'd1;
                    end
                    if (q_item.spart && partial_count_reg != '1)
                    begin
                        partial_count_next = partial_count_reg + 16'd1;
                    end
                end
            end
            ACT_QDONE:
            begin
                quality = 1'b1;
            end
            ACT_CLEAR:
            begin
                fast_count_next    = '0;
                fastest_count_next = '0;
                partial_count_next = '0;
                reading_count_next = '0;
                last_quality_next  = '0;
                total_next         = '0;
            end
            default:
            begin
            end
        endcase

        if (quality)
        begin
            fast_count_next    = '0;
            fastest_count_next = '0;
            partial_count_next = '0;
            reading_count_next = '0;
            last_quality_next  = q_item.now_ms;
            if (total_reg != '1)
            begin
                total_next = total_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_count_reg    <= '0;
            fastest_count_reg <= '0;
            partial_count_reg <= '0;
            reading_count_reg <= '0;
            last_quality_reg  <= '0;
            total_reg         <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                fast_count_reg    <= fast_count_next;
                fastest_count_reg <= fastest_count_next;
                partial_count_reg <= partial_count_next;
                reading_count_reg <= reading_count_next;
                last_quality_reg  <= last_quality_next;
                total_reg         <= total_next;
                out_valid_reg     <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            req_prof_reg  <= req_prof_next;
            eff_prof_reg  <= eff_prof_next;
            reason_reg    <= reason_next;
            partial_reg   <= partial_next;
            time_reg      <= time_next;
            forced_reg    <= forced_next;
            cause_reg     <= cause_next;
            total_out_reg <= total_next;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.requested_profile = req_prof_reg;
    assign result.effective_profile = eff_prof_reg;
    assign result.result_reason     = reason_reg;
    assign result.result_partial    = partial_reg;
    assign result.submitted_time    = time_reg;
    assign result.cleanup_forced    = forced_reg;
    assign result.cleanup_cause     = cause_reg;
    assign result.cleanup_total     = total_out_reg;
endmodule

`default_nettype wire

>>> rtl/epaper_refresh_mode_policy.sv
// Top level of the e-paper refresh profile policy.
//
// Channels: request (sink) carries one item per refresh event: an action
// (decide, submit, quality completed, clear) with the request fields.
// result (source) returns exactly one item per request item.
// Configuration: cfg_we/cfg_index/cfg_wdata write one register per cycle;
// write only while no request item is in flight.
//
// Path: an accepted item is classified into a two-entry queue, then the
// counter/policy stage loads the result register when the result side
// is ready.
// Throughput: one item per cycle while result.ready stays high, with the
// counter update in the policy stage.
// Stall: while result.ready is low the result register holds; the queue
// takes up to two more items, then request.ready drops.
// Reset: counters, last quality time and cleanup total go to zero, the
// queue and result register empty, registers take their default values.
`timescale 1ns / 1ps
`default_nettype none

module epaper_refresh_mode_policy (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    epr_in_if.sink                             request,
    epr_out_if.source                          result,
    input  wire logic                          cfg_we,
    input  wire logic [epr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [epr_pkg::CFG_DAT_W-1:0] cfg_wdata
);
    import epr_pkg::*;

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    logic    q_full;
    logic    push;
    q_item_t push_item;
    logic    q_valid;
    q_item_t head_item;
    logic    pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RAPID_TURNS: cfg_next.rapid_turns_for_fastest = cfg_wdata[TURNS_W-1:0];
                CFG_FASTEST_LIM: cfg_next.fastest_cap             = cfg_wdata[COUNT_W-1:0];
                CFG_FAST_LIM:    cfg_next.fast_cap                = cfg_wdata[COUNT_W-1:0];
                CFG_READING_LIM: cfg_next.reading_cap             = cfg_wdata[COUNT_W-1:0];
                CFG_TIMEOUT:     cfg_next.quality_timeout_ms      = cfg_wdata[TIME_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rapid_turns_for_fastest <= RST_RAPID_TURNS;
            cfg_reg.fastest_cap             <= RST_FASTEST_LIM;
            cfg_reg.fast_cap                <= RST_FAST_LIM;
            cfg_reg.reading_cap             <= RST_READING_LIM;
            cfg_reg.quality_timeout_ms      <= RST_TIMEOUT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    epr_front u_front (
        .rapid_turns_for_fastest (cfg_reg.rapid_turns_for_fastest),
        .request                 (request),
        .q_full                  (q_full),
        .push                    (push),
        .push_item               (push_item)
    );

    epr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .valid     (q_valid),
        .head_item (head_item)
    );

    epr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_item  (head_item),
        .pop     (pop),
        .result  (result)
    );
endmodule

`default_nettype wire
